// ----- hdl/text_to_utf8_transcoder_macros.svh -----
// Assertion macros shared by the transcoder RTL.
// Included by the modules that carry concurrent assertions.
`ifndef TEXT_TO_UTF8_TRANSCODER_MACROS_SVH
`define TEXT_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ttu_pkg.sv -----
// Shared types, constants and encoding functions of the text to UTF-8 transcoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ttu_pkg;

    typedef enum logic [1:0] {
        MODE_UTF8    = 2'd0,
        MODE_CP1252  = 2'd1,
        MODE_UTF16BE = 2'd2,
        MODE_UTF16LE = 2'd3
    } ttu_mode_t;

    // Register map: index of encoding_mode in the register list.
    localparam int unsigned CFG_ADDR_W          = 3;
    localparam logic        CFG_IDX_ENCODING    = 1'b0;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // One queued job: up to two code points produced by one input byte.
    typedef struct packed {
        logic        raw;    // pass cp0[7:0] through as a single byte
        logic [1:0]  n_cp;   // 1 or 2 code points
        logic [20:0] cp0;
        logic [20:0] cp1;
        logic        last;   // job comes from the final byte of the text
    } ttu_job_t;

    // Windows-1252 code points for bytes 0x80 to 0x9F.
    function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:    cp = 16'h20AC;
            5'd1:    cp = 16'h0081;
            5'd2:    cp = 16'h201A;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201E;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02C6;
            5'd9:    cp = 16'h2030;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd13:   cp = 16'h008D;
            5'd14:   cp = 16'h017D;
            5'd15:   cp = 16'h008F;
            5'd16:   cp = 16'h0090;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201C;
            5'd20:   cp = 16'h201D;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02DC;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203A;
            5'd28:   cp = 16'h0153;
            5'd29:   cp = 16'h009D;
            5'd30:   cp = 16'h017E;
            default: cp = 16'h0178;
        endcase
        return cp;
    endfunction

    // Number of UTF-8 bytes for a code point, minus one.
    function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
        logic [1:0] n;
        if (cp < 21'h000080) begin
            n = 2'd0;
        end
        else if (cp < 21'h000800) begin
            n = 2'd1;
        end
        else if (cp < 21'h010000) begin
            n = 2'd2;
        end
        else begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Byte k of the UTF-8 form of cp, whose length minus one is len_m1.
    function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp,
                                                input logic [1:0]  len_m1,
                                                input logic [1:0]  k);
        logic [7:0] b;
        logic [1:0] grp;
        grp = len_m1 - k;
        if (k == 2'd0) begin
            case (len_m1)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = {3'b110, cp[10:6]};
                2'd2:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end
        else begin
            case (grp)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ttu_in_if.sv -----
// Input channel of the transcoder: one raw byte and its end-of-text mark.
// No dependencies.
`default_nettype none

interface ttu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/ttu_out_if.sv -----
// Output channel of the transcoder: one UTF-8 byte with its framing marks.
// No dependencies.
`default_nettype none

interface ttu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output utf8_byte, output run_last, output stream_end,
                    input ready);
    modport sink (input valid, input utf8_byte, input run_last, input stream_end,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/text_to_utf8_transcoder.sv -----
// Top level with the configuration register; uses ttu_pkg and all ttu modules.
// An accepted byte's job is written into the job queue; the back end then loads its
// first UTF-8 byte into the output register and emits one byte per cycle while a job
// is queued and the output is not stalled. An input byte yields zero to six bytes (at
// most three in windows-1252 mode); input stalls only while the job queue is full.
// Reset clears the mode register, pairing state, queue and output.
`default_nettype none

module text_to_utf8_transcoder
    import ttu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ttu_in_if.sink                     in_ch,
    ttu_out_if.source                  out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    ttu_mode_t mode_reg;
    ttu_mode_t mode_next;
    logic      cfg_wr;
    logic      push;
    ttu_job_t  push_job;
    ttu_job_t  head_job;
    logic      pop;
    logic      q_empty;
    logic      q_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1] == CFG_IDX_ENCODING);

    assign mode_next = ttu_mode_t'(pwdata[1:0]);
    assign prdata    = (paddr[CFG_ADDR_W-1] == CFG_IDX_ENCODING) ? {30'b0, mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_UTF8;
        end
        else if (cfg_wr) begin
            mode_reg <= mode_next;
        end
    end

    ttu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    ttu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    ttu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_empty),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

// ----- hdl/ttu_front.sv -----
// Front end: accepts raw bytes, tracks UTF-16 pairing and surrogate state, and
// turns each byte into a job of up to two code points. Depends on ttu_pkg, ttu_in_if.
`default_nettype none

module ttu_front
    import ttu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ttu_mode_t mode,
    ttu_in_if.sink         in_ch,
    input  wire logic      q_full,
    output logic           push,
    output ttu_job_t       push_job
);

    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        phase_reg;
    logic        phase_next;
    logic [9:0]  pend_bits_reg;
    logic [9:0]  pend_bits_next;
    logic        pend_valid_reg;
    logic        pend_valid_next;

    logic        accept;
    logic [15:0] unit;
    logic        unit_high;
    logic        unit_low;
    logic        alone_emit;
    logic [20:0] alone_cp;
    logic [20:0] supp_cp;
    ttu_job_t    job;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    assign unit = (mode == MODE_UTF16BE) ? {held_reg, in_ch.in_byte}
                                         : {in_ch.in_byte, held_reg};
    assign unit_high = unit inside {[16'hD800:16'hDBFF]};
    assign unit_low  = unit inside {[16'hDC00:16'hDFFF]};

    // 0x10000 + ((high - 0xD800) << 10) + (low - 0xDC00), folded into one narrow add.
    assign supp_cp = {({1'b0, pend_bits_reg} + 11'h040), unit[9:0]};

    // A unit decoded on its own, not paired with a held high surrogate. A new high surrogate only
    // produces output when the text ends right after it.
    always_comb
    begin
        if (unit_high) begin
            alone_emit = in_ch.last_byte;
            alone_cp   = REPLACEMENT_CP;
        end
        else if (unit_low) begin
            alone_emit = 1'b1;
            alone_cp   = REPLACEMENT_CP;
        end
        else begin
            alone_emit = 1'b1;
            alone_cp   = {5'b0, unit};
        end
    end

    always_comb
    begin
        job             = '0;
        job.last        = in_ch.last_byte;
        held_next       = held_reg;
        phase_next      = phase_reg;
        pend_bits_next  = pend_bits_reg;
        pend_valid_next = pend_valid_reg;

        case (mode)
            MODE_UTF8:
            begin
                job.raw  = 1'b1;
                job.cp0  = {13'b0, in_ch.in_byte};
                job.n_cp = 2'd1;
            end
            MODE_CP1252:
            begin
                if (in_ch.in_byte inside {[8'h80:8'h9F]}) begin
                    job.cp0 = {5'b0, cp1252_map(in_ch.in_byte[4:0])};
                end
                else begin
                    job.cp0 = {13'b0, in_ch.in_byte};
                end
                job.n_cp = 2'd1;
            end
            default:
            begin
                if (!phase_reg) begin
                    held_next  = in_ch.in_byte;
                    phase_next = 1'b1;
                    // An odd last byte flushes a held surrogate, then itself.
                    if (in_ch.last_byte) begin
                        job.cp0  = REPLACEMENT_CP;
                        job.cp1  = REPLACEMENT_CP;
                        job.n_cp = pend_valid_reg ? 2'd2 : 2'd1;
                    end
                end
                else begin
                    phase_next = 1'b0;
                    if (pend_valid_reg && unit_low) begin
                        job.cp0         = supp_cp;
                        job.n_cp        = 2'd1;
                        pend_valid_next = 1'b0;
                    end
                    else if (pend_valid_reg) begin
                        job.cp0         = REPLACEMENT_CP;
                        job.cp1         = alone_cp;
                        job.n_cp        = alone_emit ? 2'd2 : 2'd1;
                        pend_valid_next = unit_high;
                        pend_bits_next  = unit_high ? unit[9:0] : pend_bits_reg;
                    end
                    else begin
                        job.cp0         = alone_cp;
                        job.n_cp        = {1'b0, alone_emit};
                        pend_valid_next = unit_high;
                        pend_bits_next  = unit_high ? unit[9:0] : pend_bits_reg;
                    end
                end
            end
        endcase

        // The end of the text starts the next one from a clean state.
        if (in_ch.last_byte) begin
            held_next       = 8'h00;
            phase_next      = 1'b0;
            pend_bits_next  = 10'h000;
            pend_valid_next = 1'b0;
        end
    end

    assign push     = accept && (job.n_cp != 2'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg       <= 8'h00;
            phase_reg      <= 1'b0;
            pend_bits_reg  <= 10'h000;
            pend_valid_reg <= 1'b0;
        end
        else if (accept) begin
            held_reg       <= held_next;
            phase_reg      <= phase_next;
            pend_bits_reg  <= pend_bits_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ttu_queue.sv -----
// Job queue between the front end and the UTF-8 encoder back end.
// Depends on ttu_pkg and the assertion macro header.
`default_nettype none
`include "text_to_utf8_transcoder_macros.svh"

module ttu_queue
    import ttu_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire ttu_job_t push_job,
    input  wire logic     pop,
    output ttu_job_t      head_job,
    output logic          empty,
    output logic          full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ttu_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `TTU_ASSERT_NOW(a_push_not_full, clk, rst_n, push, !full, "job pushed into a full queue")
    `TTU_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH),
        "queue count above depth")

endmodule

`default_nettype wire

// ----- hdl/ttu_back.sv -----
// Back end: walks each queued job one UTF-8 byte per cycle into an output register,
// when not stalled. Depends on ttu_pkg, ttu_out_if and the assertion macro header.
`default_nettype none
`include "text_to_utf8_transcoder_macros.svh"

module ttu_back
    import ttu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ttu_job_t head_job,
    input  wire logic     q_empty,
    output logic          pop,
    ttu_out_if.source     out_ch
);

    logic        out_valid_reg;
    logic [7:0]  utf8_byte_reg;
    logic        run_last_reg;
    logic        stream_end_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        cp_sel_reg;
    logic        cp_sel_next;

    logic        load;
    logic        advance;
    logic [20:0] cp_cur;
    logic [1:0]  len_m1;
    logic [7:0]  byte_cur;
    logic        cp_done;
    logic        job_done;

    assign load    = !out_valid_reg || out_ch.ready;
    assign advance = load && !q_empty;

    assign cp_cur   = cp_sel_reg ? head_job.cp1 : head_job.cp0;
    assign len_m1   = head_job.raw ? 2'd0 : utf8_len_m1(cp_cur);
    assign byte_cur = head_job.raw ? cp_cur[7:0] : utf8_byte_at(cp_cur, len_m1, idx_reg);
    assign cp_done  = (idx_reg == len_m1);
    assign job_done = cp_done && (cp_sel_reg == (head_job.n_cp == 2'd2));
    assign pop      = advance && job_done;

    always_comb
    begin
        idx_next    = idx_reg;
        cp_sel_next = cp_sel_reg;
        if (advance) begin
            if (cp_done) begin
                idx_next    = 2'd0;
                cp_sel_next = !job_done;
            end
            else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            cp_sel_reg    <= 1'b0;
        end
        else begin
            idx_reg    <= idx_next;
            cp_sel_reg <= cp_sel_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            utf8_byte_reg  <= byte_cur;
            run_last_reg   <= job_done;
            stream_end_reg <= job_done && head_job.last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.utf8_byte  = utf8_byte_reg;
    assign out_ch.run_last   = run_last_reg;
    assign out_ch.stream_end = stream_end_reg;

    `TTU_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, !q_empty, "pop from an empty queue")
    `TTU_ASSERT_NOW(a_idx_in_range, clk, rst_n, !q_empty, idx_reg <= len_m1,
        "byte index beyond code point length")
    `TTU_ASSERT_NOW(a_second_cp, clk, rst_n, !q_empty && cp_sel_reg, head_job.n_cp == 2'd2,
        "second code point selected on a single code point job")
    `TTU_ASSERT_NEXT(a_end_is_run_last, clk, rst_n, advance && job_done && head_job.last,
        out_ch.stream_end && out_ch.run_last, "end of text not marked on final byte")

endmodule

`default_nettype wire
